FILE: rtl/ble_crc24_whiten_encoder_unit_assert.svh
// Assertion macros for the CRC-24 and whitening encoder.
`ifndef BLE_CRC24_WHITEN_ENCODER_UNIT_ASSERT_SVH
`define BLE_CRC24_WHITEN_ENCODER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define BLECW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("encoder assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define BLECW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("encoder assertion failed");
`else
`define BLECW_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BLECW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/blecw_pkg.sv
// Types, constants and bit-level functions shared by the encoder modules.
package blecw_pkg;

   localparam int unsigned DataW    = 8;
   localparam int unsigned ChannelW = 6;
   localparam int unsigned CrcW     = 24;
   localparam int unsigned WhitenW  = 8;
   localparam int unsigned CsrDataW = 32;
   localparam int unsigned CsrAddrW = 2;

   localparam logic [CrcW-1:0]    CrcPoly        = 24'h00065B;
   localparam logic [CrcW-1:0]    CrcPresetReset = 24'h555555;
   localparam logic [WhitenW-1:0] WhitenTap      = 8'h11;
   localparam logic [WhitenW-1:0] WhitenSeedOr   = 8'h02;

   localparam int unsigned QueueDepth = 4;

   typedef struct packed {
      logic [DataW-1:0]   out_byte;
      logic               last;
      logic [CrcW-1:0]    crc;
      logic [WhitenW-1:0] lfsr;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic in_crc;
   } back_status_type;

   typedef enum logic [1:0] {
      ST_DATA,
      ST_CRC_HI,
      ST_CRC_MID,
      ST_CRC_LO
   } back_state_type;

   typedef struct packed {
      logic [WhitenW-1:0] lfsr;
      logic [DataW-1:0]   data;
   } whiten_result_type;

   function automatic logic [7:0] rev8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7-i];
      end
      return r;
   endfunction

   // Eight CRC bit steps, data taken LSB first.
   function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                                input logic [DataW-1:0] d);
      logic [CrcW-1:0] c;
      logic            fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[CrcW-1] ^ d[i];
         c  = {c[CrcW-2:0], 1'b0};
         if (fb) begin
            c = c ^ CrcPoly;
         end
      end
      return c;
   endfunction

   // Eight whitening steps; returns the advanced register and the whitened byte.
   function automatic whiten_result_type whiten_byte(input logic [WhitenW-1:0] seed,
                                                     input logic [DataW-1:0] d);
      whiten_result_type res;
      res.lfsr = seed;
      res.data = d;
      for (int i = 0; i < 8; i++) begin
         if (res.lfsr[WhitenW-1]) begin
            res.lfsr    = res.lfsr ^ WhitenTap;
            res.data[i] = ~res.data[i];
         end
         res.lfsr = {res.lfsr[WhitenW-2:0], 1'b0};
      end
      return res;
   endfunction

endpackage

FILE: rtl/blecw_channel_if.sv
// Valid/ready channel interfaces for PDU bytes in and encoded bytes out.
interface blecw_req_if;
   import blecw_pkg::*;

   logic                valid;
   logic                ready;
   logic [DataW-1:0]    data_byte;
   logic [ChannelW-1:0] channel;
   logic                last_byte;

   modport source (output valid, output data_byte, output channel, output last_byte,
                   input ready);
   modport sink (input valid, input data_byte, input channel, input last_byte,
                 output ready);
endinterface

interface blecw_rsp_if;
   import blecw_pkg::*;

   logic             valid;
   logic             ready;
   logic [DataW-1:0] out_byte;
   logic             end_of_packet;

   modport source (output valid, output out_byte, output end_of_packet, input ready);
   modport sink (input valid, input out_byte, input end_of_packet, output ready);
endinterface

FILE: rtl/blecw_queue.sv
// Small flip-flop queue between the front and back stages.
module blecw_queue #(
   parameter int unsigned QUEUE_DEPTH = blecw_pkg::QueueDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  blecw_pkg::queue_entry_type push_entry,
   input  logic                       pop,
   output blecw_pkg::queue_entry_type head_entry,
   output blecw_pkg::queue_status_type status
);
   import blecw_pkg::*;

   localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

   queue_entry_type entries_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FullCnt);
   assign status.empty = (count_ff == '0);

endmodule

FILE: rtl/blecw_front.sv
// Front stage: takes PDU bytes, runs the CRC and whitens the data byte.
module blecw_front (
   input  logic                        clock,
   input  logic                        reset,
   blecw_req_if.sink                   req,
   input  logic [blecw_pkg::CrcW-1:0]  crc_preset,
   input  blecw_pkg::queue_status_type q_status,
   output logic                        push,
   output blecw_pkg::queue_entry_type  push_entry
);
   import blecw_pkg::*;

   logic [CrcW-1:0]    crc_ff, crc_in;
   logic [WhitenW-1:0] lfsr_ff, lfsr_in;
   logic               inside_ff, inside_in;

   logic [CrcW-1:0]    cur_crc;
   logic [WhitenW-1:0] cur_lfsr;
   logic [CrcW-1:0]    new_crc;
   whiten_result_type  wres;

   assign req.ready = !q_status.full;
   assign push      = req.valid && !q_status.full;

   always_comb begin
      // The first byte of a packet starts from the preset and the channel seed.
      cur_crc  = inside_ff ? crc_ff : crc_preset;
      cur_lfsr = inside_ff ? lfsr_ff : (rev8({2'b00, req.channel}) | WhitenSeedOr);
      new_crc  = crc_byte(cur_crc, req.data_byte);
      wres     = whiten_byte(cur_lfsr, req.data_byte);

      push_entry.out_byte = rev8(wres.data);
      push_entry.last     = req.last_byte;
      push_entry.crc      = new_crc;
      push_entry.lfsr     = wres.lfsr;

      crc_in    = crc_ff;
      lfsr_in   = lfsr_ff;
      inside_in = inside_ff;
      if (push) begin
         crc_in    = new_crc;
         lfsr_in   = wres.lfsr;
         inside_in = !req.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
      end else begin
         inside_ff <= inside_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff  <= crc_in;
      lfsr_ff <= lfsr_in;
   end

endmodule

FILE: rtl/blecw_back.sv
// Back stage: emits data bytes and appends the three whitened CRC bytes.
module blecw_back (
   input  logic                        clock,
   input  logic                        reset,
   input  blecw_pkg::queue_entry_type  head_entry,
   input  blecw_pkg::queue_status_type q_status,
   output logic                        pop,
   output blecw_pkg::back_status_type  status,
   blecw_rsp_if.source                 rsp
);
   import blecw_pkg::*;

   back_state_type     state_ff, state_in;
   logic [CrcW-1:0]    crc_ff, crc_in;
   logic [WhitenW-1:0] lfsr_ff, lfsr_in;
   logic               valid_ff, valid_in;
   logic [DataW-1:0]   byte_ff, byte_in;
   logic               eop_ff, eop_in;

   logic               load_ok;
   whiten_result_type  cres;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DATA;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff  <= crc_in;
      lfsr_ff <= lfsr_in;
      byte_ff <= byte_in;
      eop_ff  <= eop_in;
   end

   always_comb begin
      load_ok = !valid_ff || rsp.ready;
      // CRC bytes go out high byte first, each reversed before whitening.
      cres    = whiten_byte(lfsr_ff, rev8(crc_ff[CrcW-1 -: 8]));

      state_in = state_ff;
      crc_in   = crc_ff;
      lfsr_in  = lfsr_ff;
      valid_in = valid_ff && !rsp.ready;
      byte_in  = byte_ff;
      eop_in   = eop_ff;
      pop      = 1'b0;

      case (state_ff)
         ST_DATA: begin
            if (load_ok && !q_status.empty) begin
               pop      = 1'b1;
               valid_in = 1'b1;
               byte_in  = head_entry.out_byte;
               eop_in   = 1'b0;
               if (head_entry.last) begin
                  state_in = ST_CRC_HI;
                  crc_in   = head_entry.crc;
                  lfsr_in  = head_entry.lfsr;
               end
            end
         end
         ST_CRC_HI, ST_CRC_MID, ST_CRC_LO: begin
            if (load_ok) begin
               valid_in = 1'b1;
               byte_in  = rev8(cres.data);
               eop_in   = (state_ff == ST_CRC_LO);
               crc_in   = {crc_ff[CrcW-9:0], 8'h00};
               lfsr_in  = cres.lfsr;
               if (state_ff == ST_CRC_HI) begin
                  state_in = ST_CRC_MID;
               end else if (state_ff == ST_CRC_MID) begin
                  state_in = ST_CRC_LO;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         default: begin
            state_in = ST_DATA;
         end
      endcase
   end

   assign rsp.valid         = valid_ff;
   assign rsp.out_byte      = byte_ff;
   assign rsp.end_of_packet = eop_ff;
   assign status.in_crc     = (state_ff != ST_DATA);

endmodule

FILE: rtl/ble_crc24_whiten_encoder_unit.sv
// Top level of the link-layer CRC-24 and whitening encoder.
//
// req_chan carries PDU bytes of a packet in order, with the channel index
// read on the first byte and last_byte set on the final one. rsp_chan returns
// one whitened, bit-reversed byte per PDU byte; the last byte is followed by
// the three CRC bytes, the third with end_of_packet set.
// An accepted item is written into the queue and then loaded into the single
// output register of the back stage, which sets the rate. Data bytes go through
// at one per cycle while rsp_chan.ready is high; after a last byte the output
// register also carries the three CRC bytes, which the queue of QUEUE_DEPTH
// entries absorbs, so a packet of n bytes gives n + 3 output bytes.
// A stall on rsp_chan holds the result; the queue keeps taking bytes until full,
// then req_chan.ready falls.
// The crc_preset register answers at every address; its low 24 bits read back as written, the upper bits as zero.
// Synchronous reset empties the queue, leaves the block outside a packet and
// sets crc_preset to 0x555555.
`include "ble_crc24_whiten_encoder_unit_assert.svh"

module ble_crc24_whiten_encoder_unit #(
   parameter int unsigned QUEUE_DEPTH = blecw_pkg::QueueDepth
) (
   input  logic                            clock,
   input  logic                            reset,
   blecw_req_if.sink                       req_chan,
   blecw_rsp_if.source                     rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [blecw_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [blecw_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic [blecw_pkg::CsrDataW-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import blecw_pkg::*;

   logic [CrcW-1:0]  crc_preset_ff, crc_preset_in;
   logic             csr_write;
   logic             push;
   logic             pop;
   queue_entry_type  push_entry;
   queue_entry_type  head_entry;
   queue_status_type q_status;
   back_status_type  b_status;

   // One register only, so every address decodes to it.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && (csr_paddr == csr_paddr);
   assign csr_prdata = {{(CsrDataW - CrcW){1'b0}}, crc_preset_ff};

   always_comb begin
      crc_preset_in = crc_preset_ff;
      if (csr_write) begin
         crc_preset_in = csr_pwdata[CrcW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_preset_ff <= CrcPresetReset;
      end else begin
         crc_preset_ff <= crc_preset_in;
      end
   end

   blecw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .crc_preset (crc_preset_ff),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   blecw_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   blecw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .status     (b_status),
      .rsp        (rsp_chan)
   );

   // A byte pushed into an empty queue leaves it non-empty in the next cycle.
   `BLECW_ASSERT_NEXT(a_push_lands, clock, reset, push && q_status.empty, !q_status.empty)
   // The CRC tail always sits behind a result that is being offered.
   `BLECW_ASSERT_IMPL(a_crc_has_output, clock, reset, b_status.in_crc, rsp_chan.valid)
   // While the third CRC byte is offered the back stage has already left the CRC tail.
   `BLECW_ASSERT_IMPL(a_eop_ends_tail, clock, reset,
      rsp_chan.valid && rsp_chan.ready && rsp_chan.end_of_packet, !b_status.in_crc)
   // A free output register with queued data always produces a result.
   `BLECW_ASSERT_NEXT(a_no_idle_output, clock, reset,
      !b_status.in_crc && !q_status.empty && (!rsp_chan.valid || rsp_chan.ready),
      rsp_chan.valid)

endmodule

FILE: dv/ble_crc24_whiten_encoder_unit_tb.sv
// Self-checking testbench for the link-layer CRC-24 and whitening encoder.
module ble_crc24_whiten_encoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import blecw_pkg::*;

   localparam logic [23:0]         Crc24Poly     = 24'h00065B;
   localparam logic [7:0]          WhitenTaps    = 8'h11;
   localparam logic [7:0]          WhitenSeedBit = 8'h02;
   localparam logic [23:0]         PresetAtReset = 24'h555555;
   localparam logic [CsrAddrW-1:0] CrcPresetAddr = '0;
   localparam int                  ItemsPerPhase = 38;
   localparam int                  ReportLimit   = 10;
   localparam int                  CycleLimit    = 200000;
   localparam int                  NumRows       = 18;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_packet;
   } enc_byte_t;

   typedef struct packed {
      logic [7:0]  data;
      logic [5:0]  channel;
      logic        last;
      logic        load_preset;
      logic [23:0] preset;
      logic        typed;
      logic [7:0]  typed_byte;
   } pdu_row_t;

   typedef enum logic [1:0] {
      ReadyAlways,
      ReadyPattern,
      ReadyMostly,
      ReadySparse
   } ready_mode_t;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CsrAddrW-1:0] csr_paddr;
   logic [CsrDataW-1:0] csr_pwdata;
   logic [CsrDataW-1:0] csr_prdata;
   logic                csr_pready;

   blecw_req_if req_chan ();
   blecw_rsp_if rsp_chan ();

   ble_crc24_whiten_encoder_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Shadow of the encoder state.
   logic [23:0] preset_shadow = PresetAtReset;
   logic [23:0] crc_state     = '0;
   logic [7:0]  whiten_state  = '0;
   logic        in_packet     = 1'b0;
   enc_byte_t   pending_bytes [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int burst_left     = 0;

   ready_mode_t ready_mode    = ReadyAlways;
   int          ready_run     = 0;
   logic [15:0] ready_pattern = '1;

   pdu_row_t directed_rows [NumRows] = '{
      '{8'h00, 6'd0,  1'b1, 1'b0, 24'h000000, 1'b1, 8'h02},
      '{8'hFF, 6'd0,  1'b1, 1'b0, 24'h000000, 1'b1, 8'hFD},
      '{8'hFF, 6'd63, 1'b1, 1'b0, 24'h000000, 1'b0, 8'h00},
      '{8'h00, 6'd63, 1'b0, 1'b0, 24'h000000, 1'b0, 8'h00},
      '{8'hFF, 6'd0,  1'b0, 1'b0, 24'h000000, 1'b0, 8'h00},
      '{8'hA5, 6'd21, 1'b0, 1'b0, 24'h000000, 1'b0, 8'h00},
      '{8'h5A, 6'd42, 1'b1, 1'b0, 24'h000000, 1'b0, 8'h00},
      '{8'h80, 6'd1,  1'b0, 1'b0, 24'h000000, 1'b0, 8'h00},
      '{8'h01, 6'd62, 1'b0, 1'b0, 24'h000000, 1'b0, 8'h00},
      '{8'h7F, 6'd32, 1'b0, 1'b0, 24'h000000, 1'b0, 8'h00},
      '{8'hFE, 6'd31, 1'b1, 1'b0, 24'h000000, 1'b0, 8'h00},
      '{8'h00, 6'd0,  1'b0, 1'b0, 24'h000000, 1'b1, 8'h02},
      '{8'h00, 6'd0,  1'b0, 1'b0, 24'h000000, 1'b0, 8'h00},
      '{8'hFF, 6'd63, 1'b0, 1'b0, 24'h000000, 1'b0, 8'h00},
      '{8'h3C, 6'd5,  1'b0, 1'b0, 24'h000000, 1'b0, 8'h00},
      // The new preset arrives inside a packet and must wait for the next one.
      '{8'hC3, 6'd9,  1'b1, 1'b1, 24'h000000, 1'b0, 8'h00},
      '{8'h00, 6'd0,  1'b1, 1'b0, 24'h000000, 1'b1, 8'h02},
      '{8'h55, 6'd17, 1'b1, 1'b0, 24'h000000, 1'b0, 8'h00}
   };

   function automatic logic [7:0] mirror8(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7-i];
      end
      return r;
   endfunction

   function automatic logic [23:0] crc24_advance(input logic [23:0] crc, input logic [7:0] d);
      logic msb;
      for (int i = 0; i < 8; i++) begin
         msb = crc[23];
         crc = {crc[22:0], 1'b0};
         if (msb != d[i]) begin
            crc = crc ^ Crc24Poly;
         end
      end
      return crc;
   endfunction

   // Whitens one byte, LSB first, advancing the shared whitening register.
   function automatic logic [7:0] whiten_and_mirror(input logic [7:0] d);
      for (int i = 0; i < 8; i++) begin
         if (whiten_state[7]) begin
            whiten_state = whiten_state ^ WhitenTaps;
            d[i] = ~d[i];
         end
         whiten_state = {whiten_state[6:0], 1'b0};
      end
      return mirror8(d);
   endfunction

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= ReportLimit) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   task automatic predict_encoding(input logic [7:0] d, input logic [5:0] ch, input logic last,
                                   input logic typed, input logic [7:0] typed_byte);
      enc_byte_t  e;
      logic [7:0] crc_part;
      if (!in_packet) begin
         crc_state    = preset_shadow;
         whiten_state = mirror8({2'b00, ch}) | WhitenSeedBit;
      end
      crc_state       = crc24_advance(crc_state, d);
      e.out_byte      = whiten_and_mirror(d);
      e.end_of_packet = 1'b0;
      if (typed) begin
         e.out_byte = typed_byte;
      end
      pending_bytes.push_back(e);
      if (!last) begin
         in_packet = 1'b1;
      end else begin
         for (int k = 0; k < 3; k++) begin
            crc_part        = crc_state[23-8*k -: 8];
            e.out_byte      = whiten_and_mirror(mirror8(crc_part));
            e.end_of_packet = (k == 2);
            pending_bytes.push_back(e);
         end
         in_packet = 1'b0;
      end
   endtask

   // Offers one PDU byte in bursts with random gaps, then records what it should give.
   task automatic send_byte(input logic [7:0] d, input logic [5:0] ch, input logic last,
                            input logic typed, input logic [7:0] typed_byte);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= d;
      req_chan.channel   <= ch;
      req_chan.last_byte <= last;
      do @(posedge clock); while (!req_chan.ready);
      predict_encoding(d, ch, last, typed, typed_byte);
   endtask

   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   // Writes crc_preset with junk in the unused upper bits, then reads it back.
   task automatic write_preset(input logic [23:0] value);
      logic [7:0]          junk;
      logic [CsrDataW-1:0] readback;
      junk = 8'($urandom_range(0, 255));
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CrcPresetAddr;
      csr_pwdata  <= {junk, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      preset_shadow = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[23:0] !== value) begin
         flag_mismatch($sformatf("crc_preset read back: expected %06h, got %06h",
                                 value, readback[23:0]));
      end
   endtask

   always @(negedge clock) begin
      if (ready_run == 0) begin
         ready_mode    = ready_mode_t'($urandom_range(0, 3));
         ready_run     = $urandom_range(6, 48);
         ready_pattern = 16'($urandom);
      end
      ready_run--;
      ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
      case (ready_mode)
         ReadyAlways: begin
            rsp_chan.ready <= 1'b1;
         end
         ReadyPattern: begin
            rsp_chan.ready <= ready_pattern[0];
         end
         ReadyMostly: begin
            rsp_chan.ready <= ready_pattern[0] | ready_pattern[5];
         end
         default: begin
            rsp_chan.ready <= ready_pattern[0] & ready_pattern[9];
         end
      endcase
   end

   always @(posedge clock) begin : check_output
      enc_byte_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_bytes.size() == 0) begin
            flag_mismatch($sformatf("unexpected item: out_byte %02h end_of_packet %0b",
                                    rsp_chan.out_byte, rsp_chan.end_of_packet));
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_chan.out_byte !== want.out_byte) begin
               flag_mismatch($sformatf("out_byte: expected %02h, got %02h",
                                       want.out_byte, rsp_chan.out_byte));
            end
            if (rsp_chan.end_of_packet !== want.end_of_packet) begin
               flag_mismatch($sformatf("end_of_packet: expected %0b, got %0b",
                                       want.end_of_packet, rsp_chan.end_of_packet));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL ble_crc24_whiten_encoder_unit");
         $finish;
      end
   end

   initial begin : stimulus
      int          count;
      int          bytes_left;
      logic [23:0] phase_preset;
      logic [7:0]  d;
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.channel   = '0;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready     = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NumRows; i++) begin
         if (directed_rows[i].load_preset) begin
            settle();
            write_preset(directed_rows[i].preset);
         end
         send_byte(directed_rows[i].data, directed_rows[i].channel, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].typed_byte);
      end
      settle();

      // Random packets; the second phase may stop inside a packet, so the
      // next preset is written while a packet is still open.
      bytes_left = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: phase_preset = 24'hFFFFFF;
            1: phase_preset = 24'($urandom_range(0, 24'hFFFFFF));
            2: phase_preset = 24'($urandom_range(0, 24'hFFFFFF));
            default: phase_preset = PresetAtReset;
         endcase
         write_preset(phase_preset);
         count = 0;
         while (count < ItemsPerPhase || (phase != 1 && bytes_left != 0)) begin
            if (bytes_left == 0) begin
               if ($urandom_range(0, 5) == 0) begin
                  bytes_left = 1;
               end else if ($urandom_range(0, 9) == 0) begin
                  bytes_left = $urandom_range(9, 24);
               end else begin
                  bytes_left = $urandom_range(2, 8);
               end
            end
            case ($urandom_range(0, 7))
               0: d = 8'h00;
               1: d = 8'hFF;
               default: d = 8'($urandom_range(0, 255));
            endcase
            send_byte(d, 6'($urandom_range(0, 63)), bytes_left == 1, 1'b0, 8'h00);
            bytes_left--;
            count++;
         end
         settle();
      end

      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && pending_bytes.size() == 0) begin
         $display("PASS ble_crc24_whiten_encoder_unit");
      end else begin
         $display("FAIL ble_crc24_whiten_encoder_unit");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/blecw_pkg.sv
rtl/blecw_channel_if.sv
rtl/blecw_queue.sv
rtl/blecw_front.sv
rtl/blecw_back.sv
rtl/ble_crc24_whiten_encoder_unit.sv
dv/ble_crc24_whiten_encoder_unit_tb.sv
